[hdl/tdsm_pkg.sv]
package tdsm_pkg;

  localparam int WINDOW_DEF = 32;
  localparam int ADC_BITS   = 12;

  localparam int SI_W   = 16;
  localparam int UI_W   = 16;
  localparam int FS_W   = 12;
  localparam int VREF_W = 13;
  localparam int TEMP_W = 10;
  localparam int MV_W   = 13;
  localparam int TDS_W  = 18;
  localparam int CNT_W  = 32;
  localparam int CIDX_W = 8;
  localparam int CDAT_W = 16;

  localparam int ACC_W  = 64;
  localparam int MA_W   = 34;
  localparam int MB_W   = 32;
  localparam int DVS_W  = 45;
  localparam int U_W    = 17;

  localparam logic [CIDX_W-1:0] REG_SAMPLE_INT = 8'd0;
  localparam logic [CIDX_W-1:0] REG_UPDATE_INT = 8'd1;
  localparam logic [CIDX_W-1:0] REG_FULL_SCALE = 8'd2;
  localparam logic [CIDX_W-1:0] REG_VREF       = 8'd3;

  localparam logic [SI_W-1:0]   SI_RST   = 16'd40;
  localparam logic [UI_W-1:0]   UI_RST   = 16'd800;
  localparam logic [FS_W-1:0]   FS_RST   = 12'd4095;
  localparam logic [VREF_W-1:0] VREF_RST = 13'd3300;

  localparam logic [MV_W-1:0]   MV_MAX    = 13'd8191;
  localparam logic [TDS_W-1:0]  TDS_MAX   = 18'd200000;
  localparam logic [ACC_W-1:0]  U_SAT     = 64'd72000;
  localparam logic [MB_W-1:0]   K_UNIT    = 32'd5000;
  localparam logic [TEMP_W:0]   K_TOFS    = 11'd250;
  localparam logic [MB_W-1:0]   K_C3      = 32'd13342;
  localparam logic [MB_W-1:0]   K_C2      = 32'd255860000;
  localparam logic [MA_W-1:0]   K_C1      = 34'd85739;
  localparam logic [MB_W-1:0]   K_E8      = 32'd100000000;
  localparam logic [DVS_W-1:0]  K_TDS_DIV = 45'd20000000000000;

  typedef enum logic [1:0] {
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_e;

  typedef struct packed {
    logic    en;
    mac_op_e op;
    logic    shift;
  } mac_ctl_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CAND_RD,
    ST_CAND_LD,
    ST_SCAN,
    ST_VMUL,
    ST_VGO,
    ST_VWT,
    ST_UMUL,
    ST_UGO,
    ST_UWT,
    ST_C1,
    ST_C2,
    ST_C3,
    ST_C4,
    ST_C5,
    ST_C6,
    ST_TGO,
    ST_TWT,
    ST_FIN
  } state_e;

endpackage

[hdl/tdsm_if.sv]
interface tdsm_in_if;
  import tdsm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ADC_BITS-1:0]   raw_sample;
  logic                  read_ok;
  logic [TEMP_W-1:0]     water_temp;
  modport source (output valid, raw_sample, read_ok, water_temp, input ready);
  modport sink   (input valid, raw_sample, read_ok, water_temp, output ready);
endinterface

interface tdsm_out_if;
  import tdsm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [ADC_BITS-1:0]   median_code;
  logic [MV_W-1:0]       voltage_mv;
  logic [TDS_W-1:0]      tds_tenth_ppm;
  logic                  fault;
  logic [CNT_W-1:0]      good_updates;
  modport source (output valid, median_code, voltage_mv, tds_tenth_ppm, fault, good_updates,
                  input ready);
  modport sink   (input valid, median_code, voltage_mv, tds_tenth_ppm, fault, good_updates,
                  output ready);
endinterface

interface tdsm_cfg_if;
  import tdsm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CIDX_W-1:0]     index;
  logic [CDAT_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/tdsm_ring.sv]
module tdsm_ring #(
  parameter int Window = tdsm_pkg::WINDOW_DEF,
  parameter int PtrW   = (Window > 1) ? $clog2(Window) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          wr_en_i,
  input  logic [tdsm_pkg::ADC_BITS-1:0] wr_data_i,
  input  logic [PtrW-1:0]               rd_addr_i,
  output logic [tdsm_pkg::ADC_BITS-1:0] rd_data_o
);
  import tdsm_pkg::*;

  logic [ADC_BITS-1:0] mem [Window];
  logic [Window-1:0]   vld_q;
  logic [PtrW-1:0]     ptr_q;
  logic [ADC_BITS-1:0] rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      ptr_q <= '0;
    end else if (wr_en_i) begin
      vld_q[ptr_q] <= 1'b1;
      ptr_q <= (ptr_q == PtrW'(Window - 1)) ? '0 : ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[ptr_q] <= wr_data_i;
    end
    rd_q <= vld_q[rd_addr_i] ? mem[rd_addr_i] : '0;
  end

  assign rd_data_o = rd_q;
endmodule

[hdl/tdsm_div.sv]
module tdsm_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [tdsm_pkg::ACC_W-1:0] dividend_i,
  input  logic [tdsm_pkg::DVS_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [tdsm_pkg::ACC_W-1:0] quot_o
);
  import tdsm_pkg::*;

  localparam int StepW = $clog2(ACC_W);

  logic             busy_q, done_q;
  logic [StepW-1:0] step_q;
  logic [ACC_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   rem_q;
  logic [DVS_W+1:0] rem_sh, rem_sub;

  assign rem_sh  = {rem_q, quo_q[ACC_W-1]};
  assign rem_sub = rem_sh - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(ACC_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (!rem_sub[DVS_W+1]) begin
        rem_q <= rem_sub[DVS_W:0];
        quo_q <= {quo_q[ACC_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh[DVS_W:0];
        quo_q <= {quo_q[ACC_W-2:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
endmodule

[hdl/tdsm_mac.sv]
module tdsm_mac (
  input  logic                       clk_i,
  input  tdsm_pkg::mac_ctl_t         ctl_i,
  input  logic [tdsm_pkg::MA_W-1:0]  a_i,
  input  logic [tdsm_pkg::MB_W-1:0]  b_i,
  output logic [tdsm_pkg::ACC_W-1:0] acc_o
);
  import tdsm_pkg::*;

  logic [MA_W+MB_W-1:0] prod;
  logic [ACC_W-1:0]     term, acc_q;

  assign prod = a_i * b_i;
  assign term = ctl_i.shift ? {prod[MA_W-1:0], 30'b0} : prod[ACC_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      case (ctl_i.op)
        MAC_LOAD: acc_q <= term;
        MAC_ADD:  acc_q <= acc_q + term;
        MAC_SUB:  acc_q <= acc_q - term;
        default:  acc_q <= term;
      endcase
    end
  end

  assign acc_o = acc_q;
endmodule

[hdl/tds_median_conductivity_monitor.sv]
// A good update runs a rank-count median over the ring's single read port,
// then up to three 64-step divisions; the last is skipped when the voltage
// term saturates. Throughput: one tick per cycle between updates while the
// output is not stalled; one update in flight, no ticks taken meanwhile.
// A fault update is emitted the cycle after its tick. Reset clears the ring
// through valid bits, the counters, held values and config to defaults.
module tds_median_conductivity_monitor #(
  parameter int Window = tdsm_pkg::WINDOW_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  tdsm_in_if.sink    in_i,
  tdsm_cfg_if.sink   cfg_i,
  tdsm_out_if.source out_o
);
  import tdsm_pkg::*;

  localparam int PtrW = (Window > 1) ? $clog2(Window) : 1;
  localparam int CntW = $clog2(Window + 1);
  localparam int Rlo  = (Window - 1) / 2;
  localparam int Rhi  = Window / 2;

  logic [SI_W-1:0]   si_q;
  logic [UI_W-1:0]   ui_q;
  logic [FS_W-1:0]   fs_q;
  logic [VREF_W-1:0] vref_q;

  logic [SI_W-1:0] stc_q, stc_n;
  logic [UI_W-1:0] utc_q, utc_n;
  logic            do_s, do_u, smp_ok, in_acc;
  logic            fault_q, fault_n;

  logic [ADC_BITS-1:0] hmed_q, hmed_d;
  logic [MV_W-1:0]     hmv_q, hmv_d;
  logic [TDS_W-1:0]    htds_q, htds_d;
  logic [CNT_W-1:0]    ucnt_q;
  logic                hold_ld;

  logic                 ov_q, ov_d, out_ld, out_free;
  logic [ADC_BITS-1:0]  omed_q;
  logic [MV_W-1:0]      omv_q;
  logic [TDS_W-1:0]     otds_q;
  logic                 oflt_q, oflt_d;
  logic [CNT_W-1:0]     ocnt_q, ocnt_d;

  state_e state_q, state_d;

  logic [TEMP_W-1:0]   temp_q;
  logic [PtrW-1:0]     ic_q, ic_d, jq_q, jq_d, rd_addr;
  logic [ADC_BITS-1:0] cand_q, cand_d, vlo_q, vlo_d, vhi_q, vhi_d, rd_data;
  logic [CntW-1:0]     lt_q, le_q, lt_n, le_n, lt_d, le_d;
  logic [ADC_BITS:0]   med_sum;
  logic [U_W-1:0]      u_q, u_d;
  logic [29:0]         gl_q, gl_d;
  logic [MV_W-1:0]     mv_q, mv_d;
  logic [TDS_W-1:0]    tds_q, tds_d;

  mac_ctl_t         mctl;
  logic [MA_W-1:0]  ma;
  logic [MB_W-1:0]  mb;
  logic [ACC_W-1:0] acc;

  logic             dv_start, dv_done;
  logic [DVS_W-1:0] dv_dvs;
  logic [ACC_W-1:0] dv_quot;

  assign out_free = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == ST_IDLE) && out_free;
  assign in_acc = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  always_comb begin
    stc_n = (stc_q < 16'hFFFF) ? stc_q + 1'b1 : stc_q;
    utc_n = (utc_q < 16'hFFFF) ? utc_q + 1'b1 : utc_q;
    do_s  = stc_n >= si_q;
    do_u  = utc_n >= ui_q;
    smp_ok  = in_i.read_ok && ({4'b0, in_i.raw_sample} < {4'b0, fs_q});
    fault_n = do_s ? !smp_ok : fault_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      si_q   <= SI_RST;
      ui_q   <= UI_RST;
      fs_q   <= FS_RST;
      vref_q <= VREF_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        REG_SAMPLE_INT: si_q   <= cfg_i.data;
        REG_UPDATE_INT: ui_q   <= cfg_i.data;
        REG_FULL_SCALE: fs_q   <= cfg_i.data[FS_W-1:0];
        REG_VREF:       vref_q <= cfg_i.data[VREF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stc_q   <= '0;
      utc_q   <= '0;
      fault_q <= 1'b0;
      hmed_q  <= '0;
      hmv_q   <= '0;
      htds_q  <= '0;
      ucnt_q  <= '0;
      ov_q    <= 1'b0;
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      if (in_acc) begin
        stc_q   <= do_s ? '0 : stc_n;
        utc_q   <= do_u ? '0 : utc_n;
        fault_q <= fault_n;
      end
      if (hold_ld) begin
        hmed_q <= hmed_d;
        hmv_q  <= hmv_d;
        htds_q <= htds_d;
        ucnt_q <= ucnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      temp_q <= in_i.water_temp;
    end
    ic_q   <= ic_d;
    jq_q   <= jq_d;
    cand_q <= cand_d;
    vlo_q  <= vlo_d;
    vhi_q  <= vhi_d;
    lt_q   <= lt_d;
    le_q   <= le_d;
    u_q    <= u_d;
    gl_q   <= gl_d;
    mv_q   <= mv_d;
    tds_q  <= tds_d;
    if (out_ld) begin
      omed_q <= hmed_d;
      omv_q  <= hmv_d;
      otds_q <= htds_d;
      oflt_q <= oflt_d;
      ocnt_q <= ocnt_d;
    end
  end

  assign med_sum = {1'b0, vlo_q} + {1'b0, vhi_q};
  assign lt_n = lt_q + CntW'(rd_data < cand_q);
  assign le_n = le_q + CntW'(rd_data <= cand_q);

  always_comb begin
    state_d  = state_q;
    ov_d     = ov_q && !out_o.ready;
    out_ld   = 1'b0;
    hold_ld  = 1'b0;
    oflt_d   = 1'b0;
    ocnt_d   = ucnt_q + 1'b1;
    hmed_d   = med_sum[ADC_BITS:1];
    hmv_d    = hmv_q;
    htds_d   = htds_q;
    ic_d     = ic_q;
    jq_d     = jq_q;
    cand_d   = cand_q;
    vlo_d    = vlo_q;
    vhi_d    = vhi_q;
    lt_d     = lt_q;
    le_d     = le_q;
    u_d      = u_q;
    gl_d     = gl_q;
    mv_d     = mv_q;
    tds_d    = tds_q;
    rd_addr  = ic_q;
    mctl     = '{en: 1'b0, op: MAC_LOAD, shift: 1'b0};
    ma       = '0;
    mb       = '0;
    dv_start = 1'b0;
    dv_dvs   = K_TDS_DIV;

    case (state_q)
      ST_IDLE: begin
        ic_d = '0;
        if (in_acc && do_u) begin
          if (fault_n) begin
            out_ld = 1'b1;
            ov_d   = 1'b1;
            hmed_d = hmed_q;
            oflt_d = 1'b1;
            ocnt_d = ucnt_q;
          end else begin
            state_d = ST_CAND_RD;
          end
        end
      end
      ST_CAND_RD: begin
        state_d = ST_CAND_LD;
      end
      ST_CAND_LD: begin
        cand_d  = rd_data;
        rd_addr = '0;
        jq_d    = '0;
        lt_d    = '0;
        le_d    = '0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        rd_addr = jq_q + 1'b1;
        jq_d    = jq_q + 1'b1;
        lt_d    = lt_n;
        le_d    = le_n;
        if (jq_q == PtrW'(Window - 1)) begin
          if (lt_n <= CntW'(Rlo) && CntW'(Rlo) < le_n) begin
            vlo_d = cand_q;
          end
          if (lt_n <= CntW'(Rhi) && CntW'(Rhi) < le_n) begin
            vhi_d = cand_q;
          end
          ic_d    = ic_q + 1'b1;
          rd_addr = ic_q + 1'b1;
          state_d = (ic_q == PtrW'(Window - 1)) ? ST_VMUL : ST_CAND_RD;
        end
      end
      ST_VMUL: begin
        mctl    = '{en: 1'b1, op: MAC_LOAD, shift: 1'b0};
        ma      = MA_W'(med_sum[ADC_BITS:1]);
        mb      = MB_W'(vref_q);
        state_d = ST_VGO;
      end
      ST_VGO: begin
        dv_start = 1'b1;
        dv_dvs   = (fs_q == '0) ? DVS_W'(1) : DVS_W'(fs_q);
        state_d  = ST_VWT;
      end
      ST_VWT: begin
        if (dv_done) begin
          mv_d    = (dv_quot > ACC_W'(MV_MAX)) ? MV_MAX : dv_quot[MV_W-1:0];
          state_d = ST_UMUL;
        end
      end
      ST_UMUL: begin
        mctl    = '{en: 1'b1, op: MAC_LOAD, shift: 1'b0};
        ma      = MA_W'(mv_q);
        mb      = K_UNIT;
        state_d = ST_UGO;
      end
      ST_UGO: begin
        dv_start = 1'b1;
        dv_dvs   = DVS_W'({1'b0, temp_q} + K_TOFS);
        state_d  = ST_UWT;
      end
      ST_UWT: begin
        if (dv_done) begin
          u_d = dv_quot[U_W-1:0];
          if (dv_quot >= U_SAT) begin
            tds_d   = TDS_MAX;
            state_d = ST_FIN;
          end else begin
            state_d = ST_C1;
          end
        end
      end
      ST_C1: begin
        mctl    = '{en: 1'b1, op: MAC_LOAD, shift: 1'b0};
        ma      = MA_W'(u_q);
        mb      = MB_W'(u_q);
        state_d = ST_C2;
      end
      ST_C2: begin
        mctl    = '{en: 1'b1, op: MAC_LOAD, shift: 1'b0};
        ma      = acc[MA_W-1:0];
        mb      = K_C3;
        state_d = ST_C3;
      end
      ST_C3: begin
        mctl    = '{en: 1'b1, op: MAC_SUB, shift: 1'b0};
        ma      = MA_W'(u_q);
        mb      = K_C2;
        state_d = ST_C4;
      end
      ST_C4: begin
        mctl    = '{en: 1'b1, op: MAC_ADD, shift: 1'b0};
        ma      = K_C1;
        mb      = K_E8;
        state_d = ST_C5;
      end
      ST_C5: begin
        mctl    = '{en: 1'b1, op: MAC_LOAD, shift: 1'b1};
        ma      = acc[ACC_W-1:30];
        mb      = MB_W'(u_q);
        gl_d    = acc[29:0];
        state_d = ST_C6;
      end
      ST_C6: begin
        mctl    = '{en: 1'b1, op: MAC_ADD, shift: 1'b0};
        ma      = MA_W'(u_q);
        mb      = MB_W'(gl_q);
        state_d = ST_TGO;
      end
      ST_TGO: begin
        dv_start = 1'b1;
        state_d  = ST_TWT;
      end
      ST_TWT: begin
        if (dv_done) begin
          // a negative cubic result, marked by the sign bit, is clamped to zero
          if (acc[ACC_W-1]) begin
            tds_d = '0;
          end else begin
            tds_d = (dv_quot > ACC_W'(TDS_MAX)) ? TDS_MAX : dv_quot[TDS_W-1:0];
          end
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        hmv_d  = mv_q;
        htds_d = tds_q;
        if (out_free) begin
          hold_ld = 1'b1;
          out_ld  = 1'b1;
          ov_d    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  tdsm_ring #(
    .Window (Window)
  ) u_ring (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (in_acc && do_s && smp_ok),
    .wr_data_i (in_i.raw_sample),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  tdsm_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (mctl),
    .a_i   (ma),
    .b_i   (mb),
    .acc_o (acc)
  );

  tdsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (acc),
    .divisor_i  (dv_dvs),
    .done_o     (dv_done),
    .quot_o     (dv_quot)
  );

  assign out_o.valid         = ov_q;
  assign out_o.median_code   = omed_q;
  assign out_o.voltage_mv    = omv_q;
  assign out_o.tds_tenth_ppm = otds_q;
  assign out_o.fault         = oflt_q;
  assign out_o.good_updates  = ocnt_q;
endmodule

[tb/tdsm_tb_if.sv]
`timescale 1ns / 1ps
// Interfaces come from the RTL file hdl/tdsm_if.sv; nothing extra is needed here.
// This file only holds the word type shared by the testbench top.
package tdsm_tb_pkg;
  import tdsm_pkg::*;

  typedef struct {
    logic [ADC_BITS-1:0] median_code;
    logic [MV_W-1:0]     voltage_mv;
    logic [TDS_W-1:0]    tds_tenth_ppm;
    logic                fault;
    logic [CNT_W-1:0]    good_updates;
  } tds_word_t;
endpackage

[tb/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import tdsm_pkg::*;
  import tdsm_tb_pkg::*;

  localparam int WIN = WINDOW_DEF;
  localparam int SETTLE = 2000;

  class tds_scoreboard;
    logic [SI_W-1:0]     smp_int;
    logic [UI_W-1:0]     upd_int;
    logic [FS_W-1:0]     full_scale;
    logic [VREF_W-1:0]   vref;
    logic [ADC_BITS-1:0] ring[WIN];
    int                  wr_ptr;
    int unsigned         smp_cnt, upd_cnt;
    bit                  flt;
    logic [ADC_BITS-1:0] h_med;
    logic [MV_W-1:0]     h_mv;
    logic [TDS_W-1:0]    h_tds;
    logic [CNT_W-1:0]    n_good;
    tds_word_t           pending[$];
    int                  mismatches;

    function new();
      smp_int = SI_RST; upd_int = UI_RST; full_scale = FS_RST; vref = VREF_RST;
      foreach (ring[i]) ring[i] = '0;
      wr_ptr = 0; smp_cnt = 0; upd_cnt = 0; flt = 0;
      h_med = '0; h_mv = '0; h_tds = '0; n_good = '0; mismatches = 0;
    endfunction

    function void set_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
      case (idx)
        REG_SAMPLE_INT: smp_int = val[SI_W-1:0];
        REG_UPDATE_INT: upd_int = val[UI_W-1:0];
        REG_FULL_SCALE: full_scale = val[FS_W-1:0];
        REG_VREF:       vref = val[VREF_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [ADC_BITS-1:0] window_median();
      int unsigned s[WIN];
      foreach (ring[i]) s[i] = ring[i];
      s.sort();
      if (WIN % 2) return ADC_BITS'(s[(WIN-1)/2]);
      return ADC_BITS'((s[WIN/2] + s[WIN/2-1]) / 2);
    endfunction

    function logic [TDS_W-1:0] tds_from_mv(longint unsigned mv, longint unsigned temp);
      longint unsigned u, pos, neg, r;
      u = mv * 5000 / (temp + 250);
      if (u > 80000) u = 80000;
      pos = 13342 * u * u * u + 85739 * u * 64'd100000000;
      neg = 25586 * u * u * 10000;
      if (neg >= pos) return '0;
      r = (pos - neg) / 64'd20000000000000;
      if (r > 200000) r = 200000;
      return r[TDS_W-1:0];
    endfunction

    function void note_tick(logic [ADC_BITS-1:0] raw, logic ok, logic [TEMP_W-1:0] temp);
      bit do_s, do_u;
      longint unsigned fs, mv;
      tds_word_t w;
      if (smp_cnt < 16'hFFFF) smp_cnt++;
      do_s = smp_cnt >= smp_int;
      if (do_s) smp_cnt = 0;
      if (upd_cnt < 16'hFFFF) upd_cnt++;
      do_u = upd_cnt >= upd_int;
      if (do_u) upd_cnt = 0;
      if (do_s) begin
        if (!ok || raw >= full_scale) begin
          flt = 1;
        end else begin
          ring[wr_ptr] = raw;
          wr_ptr = (wr_ptr + 1) % WIN;
          flt = 0;
        end
      end
      if (!do_u) return;
      if (!flt) begin
        fs = (full_scale != 0) ? full_scale : 1;
        h_med = window_median();
        mv = longint'(h_med) * vref / fs;
        if (mv > MV_MAX) mv = MV_MAX;
        h_mv = mv[MV_W-1:0];
        h_tds = tds_from_mv(mv, temp);
        n_good++;
      end
      w.median_code = h_med; w.voltage_mv = h_mv; w.tds_tenth_ppm = h_tds;
      w.fault = flt; w.good_updates = n_good;
      pending.push_back(w);
    endfunction

    function void check_result(tds_word_t got);
      tds_word_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: med=%0d mv=%0d tds=%0d f=%0b n=%0d",
          got.median_code, got.voltage_mv, got.tds_tenth_ppm, got.fault, got.good_updates);
        return;
      end
      e = pending.pop_front();
      if (got.median_code !== e.median_code || got.voltage_mv !== e.voltage_mv ||
          got.tds_tenth_ppm !== e.tds_tenth_ppm || got.fault !== e.fault ||
          got.good_updates !== e.good_updates) begin
        mismatches++;
        if (mismatches <= 10) $display(
          "mismatch: exp med=%0d mv=%0d tds=%0d f=%0b n=%0d got med=%0d mv=%0d tds=%0d f=%0b n=%0d",
          e.median_code, e.voltage_mv, e.tds_tenth_ppm, e.fault, e.good_updates,
          got.median_code, got.voltage_mv, got.tds_tenth_ppm, got.fault, got.good_updates);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  tdsm_in_if  in_if();
  tdsm_cfg_if cfg_if();
  tdsm_out_if out_if();

  tds_median_conductivity_monitor uut (
    .clk_i(clk), .rst_ni(rst_n), .in_i(in_if), .cfg_i(cfg_if), .out_o(out_if)
  );

  tds_scoreboard sb = new();
  int burst_left = 0;
  int stall_mode = 0;
  int rx_phase = 0;

  initial begin
    in_if.valid = 1'b0; in_if.raw_sample = '0; in_if.read_ok = 1'b0; in_if.water_temp = '0;
    cfg_if.valid = 1'b0; cfg_if.index = '0; cfg_if.data = '0;
    out_if.ready = 1'b0;
  end

  // receiver: stall patterns are picked at random, including a stall-free one
  always @(posedge clk) begin
    tds_word_t w;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        w.median_code = out_if.median_code; w.voltage_mv = out_if.voltage_mv;
        w.tds_tenth_ppm = out_if.tds_tenth_ppm; w.fault = out_if.fault;
        w.good_updates = out_if.good_updates;
        sb.check_result(w);
      end
      rx_phase <= rx_phase + 1;
      if (rx_phase % 200 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= (rx_phase % 3) != 0;
        2: out_if.ready <= (rx_phase % 7) < 2;
        default: out_if.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  task automatic write_reg(logic [CIDX_W-1:0] idx, logic [CDAT_W-1:0] val);
    cfg_if.valid <= 1'b1; cfg_if.index <= idx; cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    sb.set_reg(idx, val);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic reconfigure(int si, int ui, int fs, int vr);
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    write_reg(REG_SAMPLE_INT, CDAT_W'(si));
    write_reg(REG_UPDATE_INT, CDAT_W'(ui));
    write_reg(REG_FULL_SCALE, CDAT_W'(fs));
    write_reg(REG_VREF, CDAT_W'(vr));
  endtask

  task automatic send_tick(logic [ADC_BITS-1:0] raw, logic ok, logic [TEMP_W-1:0] temp);
    int gap;
    in_if.valid <= 1'b1; in_if.raw_sample <= raw; in_if.read_ok <= ok;
    in_if.water_temp <= temp;
    do @(posedge clk); while (!in_if.ready);
    sb.note_tick(raw, ok, temp);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_random(int n, int fs);
    logic [ADC_BITS-1:0] raw;
    logic ok;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 8 && fs > 1) raw = ADC_BITS'($urandom_range(0, fs - 1));
      else raw = ADC_BITS'($urandom_range(0, 4095));
      ok = $urandom_range(0, 15) != 0;
      send_tick(raw, ok, TEMP_W'($urandom_range(0, 600)));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    reconfigure(1, 1, 4095, 3300);
    write_reg(8'd4, 16'h0007);
    send_tick(12'd0, 1'b1, 10'd0);
    send_tick(12'd4094, 1'b1, 10'd600);
    send_tick(12'd4095, 1'b1, 10'd250);
    send_tick(12'd2000, 1'b0, 10'd250);
    send_tick(12'd4094, 1'b1, 10'd0);
    for (int i = 0; i < 16; i++) send_tick(12'd4094, 1'b1, 10'd0);
    send_tick(12'd1000, 1'b1, 10'd600);
    send_tick(12'd4095, 1'b0, 10'd600);
    send_tick(12'd1, 1'b1, 10'd511);

    reconfigure(0, 0, 4000, 5000);
    send_random(40, 4000);

    reconfigure(3, 5, 2048, 1);
    send_random(30, 2048);
    wait_drained();
    send_random(30, 2048);

    reconfigure(2, 3, 0, 2500);
    send_random(20, 4095);

    reconfigure(1, 2, 100, 16'hFFFF);
    send_random(50, 100);

    reconfigure(65535, 65535, 4095, 3300);
    send_random(8, 4095);

    reconfigure(1, 4, 4095, 3300);
    send_random(90, 4095);

    in_if.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #50ms;
    $display("== FAIL ==");
    $finish;
  end
endmodule
